### hdl/pbtc_pkg.sv
`timescale 1ns / 1ps

package pbtc_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STACK_FULL  = 3'd1;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_ZERO_ID     = 3'd4;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] event_clock;
        logic [31:0] region_id;
    } pbtc_in_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  status;
        logic [63:0] frame_begin_clock;
        logic [63:0] frame_end_clock;
        logic        record_valid;
        logic [31:0] record_region;
        logic [31:0] call_count;
        logic [63:0] clock_sum;
        logic        last;
    } pbtc_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_POP,
        S_TAG_RD,
        S_TAG_CMP,
        S_REC_UPD,
        S_ACK,
        S_FL_RD,
        S_FL_EMIT,
        S_EMPTY
    } pbtc_state_t;

    typedef enum logic [1:0] {
        EMIT_ACK,
        EMIT_REC,
        EMIT_EMPTY
    } pbtc_emit_t;

    typedef struct packed {
        logic       load_in;
        logic       mod_start;
        logic       push;
        logic       stack_rd;
        logic       slot_init;
        logic       tag_rd;
        logic       slot_step;
        logic       tag_new;
        logic       rec_rd;
        logic       rec_upd;
        logic       fl_init;
        logic       fl_rd;
        logic       fl_step;
        logic       emit;
        pbtc_emit_t emit_sel;
        logic [2:0] ack_status;
        logic       clr_init;
        logic       clr_step;
    } pbtc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       id_zero;
        logic       stack_full;
        logic       stack_empty;
        logic       mod_done;
        logic       tag_empty;
        logic       tag_match;
        logic       table_full;
        logic       probe_last;
        logic       rec_none;
        logic       fl_last;
        logic       clr_last;
        logic       out_free;
    } pbtc_stat_t;

endpackage

### hdl/pbtc_ctrl.sv
`timescale 1ns / 1ps

module pbtc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                event_valid,
    output logic                event_stall,
    input  pbtc_pkg::pbtc_stat_t st,
    output pbtc_pkg::pbtc_cmd_t  cmd
);

    pbtc_pkg::pbtc_state_t state_reg, state_next;
    logic [2:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pbtc_pkg::S_CLEAR;
            status_reg <= pbtc_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            pbtc_pkg::S_CLEAR:
            begin
                if (st.clr_last)
                    state_next = pbtc_pkg::S_IDLE;
            end
            pbtc_pkg::S_IDLE:
            begin
                if (event_valid)
                    state_next = pbtc_pkg::S_DECODE;
            end
            pbtc_pkg::S_DECODE:
            begin
                case (st.op)
                    pbtc_pkg::OP_BEGIN:
                    begin
                        if (st.id_zero)
                        begin
                            status_next = pbtc_pkg::ST_ZERO_ID;
                            state_next  = pbtc_pkg::S_ACK;
                        end
                        else if (st.stack_full)
                        begin
                            status_next = pbtc_pkg::ST_STACK_FULL;
                            state_next  = pbtc_pkg::S_ACK;
                        end
                        else
                            state_next = pbtc_pkg::S_MOD;
                    end
                    pbtc_pkg::OP_END:
                    begin
                        if (st.stack_empty)
                        begin
                            status_next = pbtc_pkg::ST_STACK_EMPTY;
                            state_next  = pbtc_pkg::S_ACK;
                        end
                        else
                            state_next = pbtc_pkg::S_POP;
                    end
                    pbtc_pkg::OP_FRAME:
                    begin
                        state_next = st.rec_none ? pbtc_pkg::S_EMPTY : pbtc_pkg::S_FL_RD;
                    end
                    default:
                    begin
                        status_next = pbtc_pkg::ST_OK;
                        state_next  = pbtc_pkg::S_ACK;
                    end
                endcase
            end
            pbtc_pkg::S_MOD:
            begin
                if (st.mod_done)
                begin
                    status_next = pbtc_pkg::ST_OK;
                    state_next  = pbtc_pkg::S_ACK;
                end
            end
            pbtc_pkg::S_POP:
                state_next = pbtc_pkg::S_TAG_RD;
            pbtc_pkg::S_TAG_RD:
                state_next = pbtc_pkg::S_TAG_CMP;
            pbtc_pkg::S_TAG_CMP:
            begin
                if (st.tag_empty)
                begin
                    status_next = st.table_full ? pbtc_pkg::ST_TABLE_FULL : pbtc_pkg::ST_OK;
                    state_next  = pbtc_pkg::S_ACK;
                end
                else if (st.tag_match)
                    state_next = pbtc_pkg::S_REC_UPD;
                else if (st.probe_last)
                begin
                    status_next = pbtc_pkg::ST_TABLE_FULL;
                    state_next  = pbtc_pkg::S_ACK;
                end
                else
                    state_next = pbtc_pkg::S_TAG_RD;
            end
            pbtc_pkg::S_REC_UPD:
            begin
                status_next = pbtc_pkg::ST_OK;
                state_next  = pbtc_pkg::S_ACK;
            end
            pbtc_pkg::S_ACK:
            begin
                if (st.out_free)
                    state_next = pbtc_pkg::S_IDLE;
            end
            pbtc_pkg::S_FL_RD:
                state_next = pbtc_pkg::S_FL_EMIT;
            pbtc_pkg::S_FL_EMIT:
            begin
                if (st.out_free)
                    state_next = st.fl_last ? pbtc_pkg::S_CLEAR : pbtc_pkg::S_FL_RD;
            end
            pbtc_pkg::S_EMPTY:
            begin
                if (st.out_free)
                    state_next = pbtc_pkg::S_CLEAR;
            end
            default:
                state_next = pbtc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.emit_sel   = pbtc_pkg::EMIT_ACK;
        cmd.ack_status = status_reg;
        event_stall    = 1'b1;
        case (state_reg)
            pbtc_pkg::S_CLEAR:
                cmd.clr_step = 1'b1;
            pbtc_pkg::S_IDLE:
            begin
                event_stall = 1'b0;
                cmd.load_in = event_valid;
            end
            pbtc_pkg::S_DECODE:
            begin
                cmd.mod_start = (st.op == pbtc_pkg::OP_BEGIN);
                cmd.stack_rd  = (st.op == pbtc_pkg::OP_END) && !st.stack_empty;
                cmd.fl_init   = (st.op == pbtc_pkg::OP_FRAME);
            end
            pbtc_pkg::S_MOD:
                cmd.push = st.mod_done;
            pbtc_pkg::S_POP:
                cmd.slot_init = 1'b1;
            pbtc_pkg::S_TAG_RD:
                cmd.tag_rd = 1'b1;
            pbtc_pkg::S_TAG_CMP:
            begin
                cmd.tag_new   = st.tag_empty && !st.table_full;
                cmd.rec_rd    = !st.tag_empty && st.tag_match;
                cmd.slot_step = !st.tag_empty && !st.tag_match && !st.probe_last;
            end
            pbtc_pkg::S_REC_UPD:
                cmd.rec_upd = 1'b1;
            pbtc_pkg::S_ACK:
                cmd.emit = st.out_free;
            pbtc_pkg::S_FL_RD:
                cmd.fl_rd = 1'b1;
            pbtc_pkg::S_FL_EMIT:
            begin
                cmd.emit_sel = pbtc_pkg::EMIT_REC;
                cmd.emit     = st.out_free;
                cmd.fl_step  = st.out_free && !st.fl_last;
                cmd.clr_init = st.out_free && st.fl_last;
            end
            pbtc_pkg::S_EMPTY:
            begin
                cmd.emit_sel = pbtc_pkg::EMIT_EMPTY;
                cmd.emit     = st.out_free;
                cmd.clr_init = st.out_free;
            end
            default:
                event_stall = 1'b1;
        endcase
    end

endmodule

### hdl/pbtc_dp.sv
`timescale 1ns / 1ps

module pbtc_dp #(
    parameter int STACK_DEPTH  = 32,
    parameter int REGION_SLOTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbtc_pkg::pbtc_in_t   event_data,
    input  logic                 result_stall,
    output logic                 result_valid,
    output pbtc_pkg::pbtc_out_t  result_data,
    input  pbtc_pkg::pbtc_cmd_t  cmd,
    output pbtc_pkg::pbtc_stat_t st
);

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam bit POW2 = ((REGION_SLOTS & (REGION_SLOTS - 1)) == 0);

    // latched event
    logic [1:0]  op_reg;
    logic [63:0] clk_reg;
    logic [31:0] id_reg;

    // home slot remainder, four bits per cycle
    logic [RW:0]   rem_reg, rem_next;
    logic [31:0]   msh_reg;
    logic [3:0]    mcnt_reg;
    logic [RW-1:0] home;

    // open block stack
    logic [31:0]   stk_id   [STACK_DEPTH];
    logic [63:0]   stk_clk  [STACK_DEPTH];
    logic [RW-1:0] stk_home [STACK_DEPTH];
    logic [DW-1:0] depth_reg;
    logic [SW-1:0] top_idx;
    logic [31:0]   top_id_rd;
    logic [63:0]   top_clk_rd;
    logic [RW-1:0] top_home_rd;

    // probe
    logic [31:0]   pop_id_reg;
    logic [63:0]   diff_reg;
    logic [RW-1:0] slot_reg;
    logic [RW-1:0] pcnt_reg;
    logic [31:0]   tag_mem [REGION_SLOTS];
    logic [RW-1:0] idx_mem [REGION_SLOTS];
    logic [31:0]   tag_rd;
    logic [RW-1:0] idx_rd;
    logic [RW-1:0] clr_reg;

    // records
    logic [31:0]   rid_mem  [REGION_SLOTS];
    logic [31:0]   rcnt_mem [REGION_SLOTS];
    logic [63:0]   rsum_mem [REGION_SLOTS];
    logic [31:0]   rid_rd;
    logic [31:0]   rcnt_rd;
    logic [63:0]   rsum_rd;
    logic [RW-1:0] rec_addr_reg;
    logic [CW-1:0] used_reg;
    logic [RW-1:0] fl_reg;
    logic [63:0]   fbeg_reg;

    logic       out_valid_reg;
    pbtc_pkg::pbtc_out_t out_reg, out_next;

    assign top_idx = SW'(depth_reg - DW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            used_reg      <= '0;
            fbeg_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
        end
        else
        begin
            if (cmd.push)
                depth_reg <= depth_reg + DW'(1);
            else if (cmd.slot_init)
                depth_reg <= depth_reg - DW'(1);

            if (cmd.tag_new)
                used_reg <= used_reg + CW'(1);
            else if (cmd.clr_init)
                used_reg <= '0;

            if (cmd.clr_init)
            begin
                fbeg_reg <= clk_reg;
                clr_reg  <= '0;
            end
            else if (cmd.clr_step)
                clr_reg <= clr_reg + RW'(1);

            if (cmd.mod_start)
                mcnt_reg <= '0;
            else if (mcnt_reg != 4'd8)
                mcnt_reg <= mcnt_reg + 4'd1;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        for (int b = 0; b < 4; b++)
        begin
            rem_next = {rem_next[RW-1:0], msh_reg[31 - b]};
            if (rem_next >= (RW + 1)'(REGION_SLOTS))
                rem_next = rem_next - (RW + 1)'(REGION_SLOTS);
        end
    end

    assign home = POW2 ? id_reg[RW-1:0] : rem_reg[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= event_data.operation;
            clk_reg <= event_data.event_clock;
            id_reg  <= event_data.region_id;
        end
        if (cmd.mod_start)
        begin
            rem_reg <= '0;
            msh_reg <= id_reg;
        end
        else if (mcnt_reg != 4'd8)
        begin
            rem_reg <= rem_next;
            msh_reg <= {msh_reg[27:0], 4'd0};
        end

        if (cmd.push)
        begin
            stk_id[SW'(depth_reg)]   <= id_reg;
            stk_clk[SW'(depth_reg)]  <= clk_reg;
            stk_home[SW'(depth_reg)] <= home;
        end
        if (cmd.stack_rd)
        begin
            top_id_rd   <= stk_id[top_idx];
            top_clk_rd  <= stk_clk[top_idx];
            top_home_rd <= stk_home[top_idx];
        end

        if (cmd.slot_init)
        begin
            pop_id_reg <= top_id_rd;
            diff_reg   <= clk_reg - top_clk_rd;
            slot_reg   <= top_home_rd;
            pcnt_reg   <= '0;
        end
        else if (cmd.slot_step)
        begin
            slot_reg <= (slot_reg == RW'(REGION_SLOTS - 1)) ? '0 : slot_reg + RW'(1);
            pcnt_reg <= pcnt_reg + RW'(1);
        end

        if (cmd.clr_step)
            tag_mem[clr_reg] <= '0;
        else if (cmd.tag_new)
        begin
            tag_mem[slot_reg] <= pop_id_reg;
            idx_mem[slot_reg] <= used_reg[RW-1:0];
        end
        if (cmd.tag_rd)
        begin
            tag_rd <= tag_mem[slot_reg];
            idx_rd <= idx_mem[slot_reg];
        end

        if (cmd.tag_new)
        begin
            rid_mem[used_reg[RW-1:0]]  <= pop_id_reg;
            rcnt_mem[used_reg[RW-1:0]] <= 32'd1;
            rsum_mem[used_reg[RW-1:0]] <= diff_reg;
        end
        else if (cmd.rec_upd)
        begin
            rcnt_mem[rec_addr_reg] <= rcnt_rd + 32'd1;
            rsum_mem[rec_addr_reg] <= rsum_rd + diff_reg;
        end
        if (cmd.rec_rd || cmd.fl_rd)
        begin
            rid_rd  <= rid_mem[cmd.rec_rd ? idx_rd : fl_reg];
            rcnt_rd <= rcnt_mem[cmd.rec_rd ? idx_rd : fl_reg];
            rsum_rd <= rsum_mem[cmd.rec_rd ? idx_rd : fl_reg];
        end
        if (cmd.rec_rd)
            rec_addr_reg <= idx_rd;

        if (cmd.fl_init)
            fl_reg <= '0;
        else if (cmd.fl_step)
            fl_reg <= fl_reg + RW'(1);

        if (cmd.emit)
            out_reg <= out_next;
    end

    always_comb
    begin
        out_next = '0;
        case (cmd.emit_sel)
            pbtc_pkg::EMIT_ACK:
            begin
                out_next.result_kind = pbtc_pkg::KIND_ACK;
                out_next.status      = cmd.ack_status;
                out_next.last        = 1'b1;
            end
            pbtc_pkg::EMIT_REC:
            begin
                out_next.result_kind       = pbtc_pkg::KIND_RECORD;
                out_next.status            = pbtc_pkg::ST_OK;
                out_next.frame_begin_clock = fbeg_reg;
                out_next.frame_end_clock   = clk_reg;
                out_next.record_valid      = 1'b1;
                out_next.record_region     = rid_rd;
                out_next.call_count        = rcnt_rd;
                out_next.clock_sum         = rsum_rd;
                out_next.last              = st.fl_last;
            end
            pbtc_pkg::EMIT_EMPTY:
            begin
                out_next.result_kind       = pbtc_pkg::KIND_RECORD;
                out_next.status            = pbtc_pkg::ST_OK;
                out_next.frame_begin_clock = fbeg_reg;
                out_next.frame_end_clock   = clk_reg;
                out_next.last              = 1'b1;
            end
            default:
                out_next.last = 1'b1;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    assign st.op          = op_reg;
    assign st.id_zero     = (id_reg == 32'd0);
    assign st.stack_full  = (depth_reg == DW'(STACK_DEPTH));
    assign st.stack_empty = (depth_reg == '0);
    assign st.mod_done    = POW2 || (mcnt_reg == 4'd8);
    assign st.tag_empty   = (tag_rd == 32'd0);
    assign st.tag_match   = (tag_rd == pop_id_reg);
    assign st.table_full  = (used_reg == CW'(REGION_SLOTS));
    assign st.probe_last  = (pcnt_reg == RW'(REGION_SLOTS - 1));
    assign st.rec_none    = (used_reg == '0);
    assign st.fl_last     = ((CW'(fl_reg) + CW'(1)) == used_reg);
    assign st.clr_last    = (clr_reg == RW'(REGION_SLOTS - 1));
    assign st.out_free    = !out_valid_reg || !result_stall;

endmodule

### hdl/profile_block_timing_collator.sv
`timescale 1ns / 1ps
// channel   valid          stall          payload
// event     event_valid    event_stall    event_data  (pbtc_in_t)
// result    result_valid   result_stall   result_data (pbtc_out_t)
//
// begin: DECODE, MOD, ACK; MOD computes the home slot if REGION_SLOTS is not a power of two
// end: DECODE, POP, then TAG_RD and TAG_CMP per probe, REC_UPD for a known record, ACK
// events rejected in DECODE and unknown events go straight to ACK
// frame marker: FL_RD and FL_EMIT per record (EMPTY with none), then a tag slot sweep
// after reset the same sweep runs before the first transaction is taken
// a stalled result holds in the output register; the next event is taken meanwhile

module profile_block_timing_collator #(
    parameter int STACK_DEPTH  = 32,
    parameter int REGION_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                event_valid,
    output logic                event_stall,
    input  pbtc_pkg::pbtc_in_t  event_data,
    output logic                result_valid,
    input  logic                result_stall,
    output pbtc_pkg::pbtc_out_t result_data
);

    pbtc_pkg::pbtc_cmd_t  cmd;
    pbtc_pkg::pbtc_stat_t st;

    pbtc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .st          (st),
        .cmd         (cmd)
    );

    pbtc_dp #(
        .STACK_DEPTH  (STACK_DEPTH),
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_data   (event_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

### tb/tb_profile_block_timing_collator.sv
`timescale 1ns / 1ps

module tb_profile_block_timing_collator;

    localparam int STACK_DEPTH  = 32;
    localparam int REGION_SLOTS = 64;
    localparam int WATCHDOG     = 20000;
    localparam int RANDOM_ITEMS = 110;

    logic                clk;
    logic                rst_n;
    logic                event_valid;
    logic                event_stall;
    pbtc_pkg::pbtc_in_t  event_data;
    logic                result_valid;
    logic                result_stall;
    pbtc_pkg::pbtc_out_t result_data;

    profile_block_timing_collator #(
        .STACK_DEPTH (STACK_DEPTH),
        .REGION_SLOTS(REGION_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_data  (event_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

    // predictor state
    logic [31:0] open_id_stack [STACK_DEPTH];
    logic [63:0] open_clk_stack [STACK_DEPTH];
    int          stack_level;
    logic [31:0] tag_of_slot [REGION_SLOTS];
    int          index_of_slot [REGION_SLOTS];
    logic [31:0] rec_region [REGION_SLOTS];
    logic [31:0] rec_calls [REGION_SLOTS];
    logic [63:0] rec_sum [REGION_SLOTS];
    int          rec_count;
    logic [63:0] frame_start;

    pbtc_pkg::pbtc_in_t  pending_events[$];
    pbtc_pkg::pbtc_out_t expected_results[$];
    int        mismatches;
    int        idle_cycles;
    logic      ev_taken;
    bit        timed_out;
    bit        quiet_phase;
    bit        hold_sender;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pbtc_pkg::pbtc_out_t make_ack(logic [2:0] st);
        pbtc_pkg::pbtc_out_t r;
        r = '0;
        r.result_kind = pbtc_pkg::KIND_ACK;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic reset_model();
        stack_level = 0;
        rec_count = 0;
        frame_start = '0;
        for (int s = 0; s < REGION_SLOTS; s++)
            tag_of_slot[s] = '0;
    endtask

    function automatic int lookup_record(logic [31:0] id);
        int home;
        int s;
        home = id % REGION_SLOTS;
        for (int k = 0; k < REGION_SLOTS; k++)
        begin
            s = (home + k) % REGION_SLOTS;
            if (tag_of_slot[s] == 0)
            begin
                if (rec_count >= REGION_SLOTS)
                    return -1;
                tag_of_slot[s] = id;
                index_of_slot[s] = rec_count;
                rec_region[rec_count] = id;
                rec_calls[rec_count] = '0;
                rec_sum[rec_count] = '0;
                rec_count++;
                return index_of_slot[s];
            end
            if (tag_of_slot[s] == id)
                return index_of_slot[s];
        end
        return -1;
    endfunction

    task automatic collate_event(input pbtc_pkg::pbtc_in_t ev);
        pbtc_pkg::pbtc_out_t r;
        int ri;
        if (ev.operation == pbtc_pkg::OP_BEGIN)
        begin
            if (ev.region_id == 0)
                expected_results.push_back(make_ack(pbtc_pkg::ST_ZERO_ID));
            else if (stack_level >= STACK_DEPTH)
                expected_results.push_back(make_ack(pbtc_pkg::ST_STACK_FULL));
            else
            begin
                open_id_stack[stack_level] = ev.region_id;
                open_clk_stack[stack_level] = ev.event_clock;
                stack_level++;
                expected_results.push_back(make_ack(pbtc_pkg::ST_OK));
            end
        end
        else if (ev.operation == pbtc_pkg::OP_END)
        begin
            if (stack_level == 0)
                expected_results.push_back(make_ack(pbtc_pkg::ST_STACK_EMPTY));
            else
            begin
                stack_level--;
                ri = lookup_record(open_id_stack[stack_level]);
                if (ri < 0)
                    expected_results.push_back(make_ack(pbtc_pkg::ST_TABLE_FULL));
                else
                begin
                    rec_calls[ri] = rec_calls[ri] + 32'd1;
                    rec_sum[ri] = rec_sum[ri] + (ev.event_clock - open_clk_stack[stack_level]);
                    expected_results.push_back(make_ack(pbtc_pkg::ST_OK));
                end
            end
        end
        else if (ev.operation == pbtc_pkg::OP_FRAME)
        begin
            r = '0;
            r.result_kind = pbtc_pkg::KIND_RECORD;
            r.status = pbtc_pkg::ST_OK;
            r.frame_begin_clock = frame_start;
            r.frame_end_clock = ev.event_clock;
            if (rec_count == 0)
            begin
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            for (int i = 0; i < rec_count; i++)
            begin
                r.record_valid = 1'b1;
                r.record_region = rec_region[i];
                r.call_count = rec_calls[i];
                r.clock_sum = rec_sum[i];
                r.last = (i == rec_count - 1);
                expected_results.push_back(r);
            end
            for (int s = 0; s < REGION_SLOTS; s++)
                tag_of_slot[s] = '0;
            rec_count = 0;
            frame_start = ev.event_clock;
        end
        else
        begin
            expected_results.push_back(make_ack(pbtc_pkg::ST_OK));
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic pbtc_pkg::pbtc_in_t make_event(logic [1:0] op, logic [63:0] t,
                                                      logic [31:0] id);
        pbtc_pkg::pbtc_in_t e;
        e.operation = op;
        e.event_clock = t;
        e.region_id = id;
        return e;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_valid <= 1'b0;
            event_data <= '0;
        end
        else if (!event_valid || ev_taken)
        begin
            if (pending_events.size() > 0 && !hold_sender
                && (quiet_phase || $urandom_range(99) >= 11))
            begin
                event_valid <= 1'b1;
                event_data <= pending_events.pop_front();
            end
            else
            begin
                event_valid <= 1'b0;
                event_data <= make_event(2'($urandom), rand64(), $urandom);
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !quiet_phase && ($urandom_range(99) < 11);
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_model();
            mismatches = 0;
            idle_cycles <= 0;
            ev_taken <= 1'b0;
        end
        else
        begin
            ev_taken <= event_valid && !event_stall;
            if ((event_valid && !event_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (event_valid && !event_stall)
                collate_event(event_data);
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transaction %p", result_data);
                    mismatches++;
                end
                else if (result_data !== expected_results[0])
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_results[0], result_data);
                    mismatches++;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
        end
    end

    task automatic tick();
        @(posedge clk);
        if (idle_cycles > WATCHDOG)
            timed_out = 1'b1;
    endtask

    task automatic wait_drained();
        while (!timed_out
               && (pending_events.size() > 0 || event_valid || expected_results.size() > 0))
            tick();
    endtask

    task automatic wait_backlog(input int level);
        while (!timed_out && pending_events.size() > level)
            tick();
    endtask

    task automatic wait_results();
        while (!timed_out && (event_valid || expected_results.size() > 0))
            tick();
    endtask

    initial
    begin
        logic [63:0] t;
        logic [31:0] ids [8];
        int depth;
        int op;
        rst_n = 1'b0;
        timed_out = 1'b0;
        quiet_phase = 1'b0;
        hold_sender = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'd5, 32'd1));
        pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, 64'd10, 32'd0));
        pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'd20, 32'd0));
        pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'd30, 32'hFFFF_FFFF));
        pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'hFFFF_FFFF_FFFF_FFF0,
                                            32'd64));
        pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'hFFFF_FFFF_FFFF_FFF8,
                                            32'd128));
        pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'd4, 32'd0));
        pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'd40, 32'd0));
        pending_events.push_back(make_event(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, 64'hFFFF_FFFF_FFFF_FFFF,
                                            32'd0));
        wait_drained();
        // stack full, then unwind
        for (int i = 0; i <= STACK_DEPTH; i++)
            pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'(i), 32'(i + 1)));
        for (int i = 0; i < STACK_DEPTH; i++)
            pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'(100 + i), 32'd0));
        pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, 64'd500, 32'd0));
        wait_drained();
        // fill the table to the brim and beyond
        for (int i = 0; i < REGION_SLOTS + 2; i++)
        begin
            pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, 64'(1000 + i),
                                                32'(1000 + 3 * i)));
            pending_events.push_back(make_event(pbtc_pkg::OP_END, 64'(2000 + 5 * i), 32'd0));
        end
        pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, 64'd9000, 32'd0));
        wait_drained();

        // random well-formed nesting with noise, open blocks crossing frames
        quiet_phase = 1'b1;
        t = rand64();
        for (int i = 0; i < 8; i++)
            ids[i] = (i == 0) ? 32'hFFFF_FFFF : ($urandom_range(3) == 0 ? $urandom
                                                 : $urandom_range(200, 1));
        depth = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 40)
            begin
                wait_drained();
                quiet_phase = 1'b0;
            end
            if (n == 80)
            begin
                wait_backlog(10);
                hold_sender = 1'b1;
                wait_results();
                hold_sender = 1'b0;
            end
            t = t + 64'($urandom_range(1000));
            op = $urandom_range(99);
            if (op < 3)
                pending_events.push_back(make_event(2'($urandom_range(3)), rand64(),
                                                    $urandom));
            else if (op < 10)
                pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, t, $urandom));
            else if ((op < 55 && depth < 6) || depth == 0)
            begin
                pending_events.push_back(make_event(pbtc_pkg::OP_BEGIN, t,
                    ($urandom_range(20) == 0) ? 32'd0 : ids[3'($urandom_range(7))]));
                depth++;
            end
            else
            begin
                pending_events.push_back(make_event(pbtc_pkg::OP_END, t, $urandom));
                depth--;
            end
        end
        pending_events.push_back(make_event(pbtc_pkg::OP_FRAME, t + 64'd1, 32'd0));
        wait_drained();
        repeat (200) @(posedge clk);
        if (timed_out || idle_cycles > WATCHDOG)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
